// ----- rtl/tccur_pkg.sv -----
// tccur_pkg: shared types and constants for the text console cursor engine
// item payloads, cursor state, operation codes and control characters
// no dependencies
package tccur_pkg;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;

   localparam logic [1:0] OP_STREAM = 2'd0;
   localparam logic [1:0] OP_PLACE  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [7:0] TAB_STEP = 8'd8;
   localparam logic [7:0] TAB_MASK = ~(TAB_STEP - 8'd1);

   localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] character;
      logic [7:0] target_row;
      logic [7:0] target_col;
      logic [7:0] cell_color;
   } req_payload_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [CELL_W-1:0] write_cell;
      logic              scroll_up;
      logic              clear_all;
      logic [ADDR_W-1:0] cursor_position;
   } rsp_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
   } cursor_type;

endpackage

// ----- rtl/tccur_req_if.sv -----
// tccur_req_if: request channel of the cursor engine, valid/ready handshake
// depends on tccur_pkg for the payload type
interface tccur_req_if;
   logic                      valid;
   logic                      ready;
   tccur_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/tccur_rsp_if.sv -----
// tccur_rsp_if: response channel of the cursor engine, valid/ready handshake
// depends on tccur_pkg for the payload type
interface tccur_rsp_if;
   logic                      valid;
   logic                      ready;
   tccur_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/tccur_step.sv -----
// tccur_step: one item's worth of cursor logic, purely combinational
// computes the cell write, scroll/clear flags and the next cursor
// depends on tccur_pkg
module tccur_step #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  tccur_pkg::req_payload_type item,
   input  tccur_pkg::cursor_type      cursor,
   input  logic [7:0]                 text_color,
   output tccur_pkg::cursor_type      cursor_next,
   output tccur_pkg::rsp_payload_type result
);

   localparam int IDX_W = tccur_pkg::ROW_W + tccur_pkg::COL_W + 1;

   function automatic logic [tccur_pkg::ADDR_W-1:0] cell_index(
      input logic [tccur_pkg::ROW_W-1:0] r,
      input logic [tccur_pkg::COL_W-1:0] c
   );
      logic [IDX_W-1:0] full;
      full = IDX_W'(r) * IDX_W'(COLUMNS) + IDX_W'(c);
      return full[tccur_pkg::ADDR_W-1:0];
   endfunction

   logic [7:0]                   col_calc;
   logic [tccur_pkg::ROW_W:0]    row_calc;
   logic [tccur_pkg::ROW_W-1:0]  wr_row;
   logic [tccur_pkg::COL_W-1:0]  wr_col;
   logic [7:0]                   wr_attr;
   logic [7:0]                   wr_char;
   logic                         wr_en;
   logic                         scroll;
   logic                         clear;

   always_comb begin
      col_calc    = 8'(cursor.column);
      row_calc    = (tccur_pkg::ROW_W+1)'(cursor.row);
      wr_row      = cursor.row;
      wr_col      = cursor.column;
      wr_attr     = text_color;
      wr_char     = item.character;
      wr_en       = 1'b0;
      scroll      = 1'b0;
      clear       = 1'b0;
      cursor_next = cursor;

      case (item.operation)
         tccur_pkg::OP_STREAM: begin
            case (item.character)
               tccur_pkg::CH_NEWLINE: begin
                  col_calc = 8'd0;
                  row_calc = row_calc + 1'b1;
               end
               tccur_pkg::CH_RETURN: begin
                  col_calc = 8'd0;
               end
               tccur_pkg::CH_TAB: begin
                  col_calc = (col_calc + tccur_pkg::TAB_STEP) & tccur_pkg::TAB_MASK;
                  if (col_calc >= 8'(COLUMNS)) begin
                     col_calc = 8'd0;
                     row_calc = row_calc + 1'b1;
                  end
               end
               tccur_pkg::CH_BACKSPACE: begin
                  // nothing happens at the left edge
                  if (cursor.column != '0) begin
                     col_calc = col_calc - 8'd1;
                     wr_col   = cursor.column - 1'b1;
                     wr_char  = tccur_pkg::CH_SPACE;
                     wr_en    = 1'b1;
                  end
               end
               default: begin
                  // printable: write at cursor, then advance with line wrap
                  wr_en    = 1'b1;
                  col_calc = col_calc + 8'd1;
                  if (col_calc >= 8'(COLUMNS)) begin
                     col_calc = 8'd0;
                     row_calc = row_calc + 1'b1;
                  end
               end
            endcase
            if (row_calc >= (tccur_pkg::ROW_W+1)'(ROWS)) begin
               scroll   = 1'b1;
               row_calc = (tccur_pkg::ROW_W+1)'(ROWS - 1);
            end
            cursor_next.row    = row_calc[tccur_pkg::ROW_W-1:0];
            cursor_next.column = col_calc[tccur_pkg::COL_W-1:0];
         end
         tccur_pkg::OP_PLACE: begin
            wr_row  = item.target_row[tccur_pkg::ROW_W-1:0];
            wr_col  = item.target_col[tccur_pkg::COL_W-1:0];
            wr_attr = item.cell_color;
            wr_en   = (item.target_row < 8'(ROWS)) && (item.target_col < 8'(COLUMNS));
         end
         tccur_pkg::OP_CLEAR: begin
            clear       = 1'b1;
            cursor_next = '0;
         end
         default: begin
         end
      endcase

      result.write_valid     = wr_en;
      result.write_address   = wr_en ? cell_index(wr_row, wr_col) : '0;
      result.write_cell      = wr_en ? {wr_attr, wr_char} : '0;
      result.scroll_up       = scroll;
      result.clear_all       = clear;
      result.cursor_position = cell_index(cursor_next.row, cursor_next.column);
   end

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// text_console_cursor_engine: top level of the character-cell cursor engine
// depends on tccur_pkg, tccur_req_if, tccur_rsp_if and tccur_step
//
// Usage:
//   req  - one item per operation: stream a character, place a character at
//          a row/column with its own attribute, or clear the screen.
//   rsp  - exactly one item per request: optional cell write (address and
//          attribute:character), scroll and clear requests for the display
//          store, and the cursor index after the operation.
//   csr  - csr_write_enable/csr_write_data load the text color attribute;
//          write it only while no items are in flight.
// From request accept to response valid, the input register takes the item,
// then the cursor logic feeds the response register. Throughput is one item
// per cycle while the receiver takes responses; the cursor register updates
// as an item passes into the response register, so back-to-back items see
// it at once. When the receiver stalls, the response register holds and the
// input register fills; req_ready drops only when both are full.
// Reset clears the cursor to row 0, column 0, sets the text color to 7 and
// empties both registers.
module text_console_cursor_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   tccur_req_if.sink   req,
   tccur_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic                       in_valid_ff, in_valid_in;
   tccur_pkg::req_payload_type in_item_ff, in_item_in;
   logic                       out_valid_ff, out_valid_in;
   tccur_pkg::rsp_payload_type out_item_ff, out_item_in;
   tccur_pkg::cursor_type      cursor_ff, cursor_in;
   logic [7:0]                 text_color_ff, text_color_in;

   tccur_pkg::cursor_type      cursor_next;
   tccur_pkg::rsp_payload_type step_result;
   logic                       out_free;
   logic                       advance;
   logic                       accept;

   tccur_step #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_step (
      .item        (in_item_ff),
      .cursor      (cursor_ff),
      .text_color  (text_color_ff),
      .cursor_next (cursor_next),
      .result      (step_result)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_item_in    = in_item_ff;
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      cursor_in     = cursor_ff;
      text_color_in = text_color_ff;

      if (accept) begin
         in_valid_in = 1'b1;
         in_item_in  = req.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = step_result;
         cursor_in    = cursor_next;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         text_color_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         cursor_ff     <= '0;
         text_color_ff <= tccur_pkg::TEXT_COLOR_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         cursor_ff     <= cursor_in;
         text_color_ff <= text_color_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_item_ff;

endmodule

// ----- rtl/tccur_checker.sv -----
// tccur_checker: port-level assertions for the cursor engine
// bound to text_console_cursor_engine; depends on tccur_pkg
module tccur_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input tccur_pkg::rsp_payload_type rsp_payload
);

   // a stalled response item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response item changed");

   // clear homes the cursor and writes no cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.clear_all |->
         rsp_payload.cursor_position == '0 && !rsp_payload.write_valid
         && !rsp_payload.scroll_up)
      else $error("clear item carries a write, scroll or nonzero cursor");

   // no write means zeroed address and cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_valid |->
         rsp_payload.write_address == '0 && rsp_payload.write_cell == '0)
      else $error("address or cell set without a write");

   // nothing comes out in the cycle after a reset edge
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind text_console_cursor_engine tccur_checker u_tccur_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

// ----- tb/tccur_cursor_checker.sv -----
// tccur_cursor_checker: watches the request, response and register ports of the
// cursor engine, predicts every response and compares it with what comes out
// depends on tccur_pkg, tccur_req_if and tccur_rsp_if
module tccur_cursor_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tccur_req_if       req,
   tccur_rsp_if       rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         mismatch_total,
   output int         in_flight,
   output int         responses_seen,
   output int         scrolls_seen
);
   import tccur_pkg::*;

   localparam int REPORT_LIMIT = 10;

   rsp_payload_type  expected_rsp[$];
   logic [ROW_W-1:0] cursor_row;
   logic [COL_W-1:0] cursor_col;
   logic [7:0]       text_color;
   int               mismatches;
   int               checked;
   int               scrolls;

   function automatic logic [ADDR_W-1:0] cell_addr(int row, int col);
      logic [ADDR_W-1:0] addr;
      addr = ADDR_W'(row * COLUMNS + col);
      return addr;
   endfunction

   // advances the cursor copy and returns the response this item must produce
   function automatic rsp_payload_type cursor_step(req_payload_type r);
      rsp_payload_type e;
      int              row;
      int              col;
      e   = '0;
      row = cursor_row;
      col = cursor_col;
      case (r.operation)
         OP_STREAM: begin
            if (r.character == CH_NEWLINE) begin
               col = 0;
               row++;
            end else if (r.character == CH_RETURN) begin
               col = 0;
            end else if (r.character == CH_TAB) begin
               col = (col / TAB_STEP + 1) * TAB_STEP;
               if (col >= COLUMNS) begin
                  col = 0;
                  row++;
               end
            end else if (r.character == CH_BACKSPACE) begin
               // nothing happens at the left edge
               if (col > 0) begin
                  col--;
                  e.write_valid   = 1'b1;
                  e.write_address = cell_addr(row, col);
                  e.write_cell    = {text_color, CH_SPACE};
               end
            end else begin
               e.write_valid   = 1'b1;
               e.write_address = cell_addr(row, col);
               e.write_cell    = {text_color, r.character};
               col++;
               if (col >= COLUMNS) begin
                  col = 0;
                  row++;
               end
            end
            if (row >= ROWS) begin
               e.scroll_up = 1'b1;
               row = ROWS - 1;
            end
            cursor_row = ROW_W'(row);
            cursor_col = COL_W'(col);
         end
         OP_PLACE: begin
            if (r.target_row < ROWS && r.target_col < COLUMNS) begin
               e.write_valid   = 1'b1;
               e.write_address = cell_addr(r.target_row, r.target_col);
               e.write_cell    = {r.cell_color, r.character};
            end
         end
         OP_CLEAR: begin
            e.clear_all = 1'b1;
            cursor_row  = '0;
            cursor_col  = '0;
         end
         default: begin
         end
      endcase
      e.cursor_position = cell_addr(cursor_row, cursor_col);
      return e;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         expected_rsp.delete();
         cursor_row = '0;
         cursor_col = '0;
         text_color = TEXT_COLOR_RESET;
         mismatches = 0;
         checked    = 0;
         scrolls    = 0;
      end else begin
         if (csr_write_enable)
            text_color = csr_write_data;
         if (rsp.valid && rsp.ready) begin
            checked++;
            if (rsp.payload.scroll_up)
               scrolls++;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d arrived with no request waiting: %h",
                           checked, rsp.payload);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.payload !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("response %0d expected wv=%b addr=%0d cell=%h scroll=%b clr=%b cur=%0d",
                              checked, want.write_valid, want.write_address,
                              want.write_cell, want.scroll_up, want.clear_all,
                              want.cursor_position);
                     $display("response %0d got      wv=%b addr=%0d cell=%h scroll=%b clr=%b cur=%0d",
                              checked, rsp.payload.write_valid, rsp.payload.write_address,
                              rsp.payload.write_cell, rsp.payload.scroll_up,
                              rsp.payload.clear_all, rsp.payload.cursor_position);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            expected_rsp.push_back(cursor_step(req.payload));
      end
      mismatch_total <= mismatches;
      in_flight      <= expected_rsp.size();
      responses_seen <= checked;
      scrolls_seen   <= scrolls;
   end

endmodule

// ----- tb/tb.sv -----
// tb: top of the cursor engine testbench, drives requests, color writes and
// response stalls, and gives the verdict from the checker's mismatch count
// depends on tccur_pkg, both channel interfaces, the engine and tccur_cursor_checker
module tb;
   import tccur_pkg::*;

   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 5;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   int idle_pct = 0;
   int idle_count = 0;
   int items_sent = 0;
   int colors_used = 1;
   int failures;
   int in_flight;
   int responses_seen;
   int scrolls_seen;

   // per phase: items, newline share, clear share, idle share
   int phase_items[PHASES] = '{250, 250, 200, 250, 200};
   int phase_nl[PHASES]    = '{30, 2, 15, 20, 10};
   int phase_clr[PHASES]   = '{1, 1, 1, 2, 1};
   int phase_idle[PHASES]  = '{30, 30, 0, 50, 0};

   tccur_req_if req ();
   tccur_rsp_if rsp ();

   text_console_cursor_engine #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   tccur_cursor_checker #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) cursor_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .mismatch_total  (failures),
      .in_flight       (in_flight),
      .responses_seen  (responses_seen),
      .scrolls_seen    (scrolls_seen)
   );

   always #4 clock = ~clock;

   // receiver drops ready in random bursts while the idle share is nonzero
   always begin
      @(posedge clock);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp.ready <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[text_console_cursor_engine] ERROR");
            $finish;
         end
      end
   end

   function automatic req_payload_type make_req(logic [1:0] op, logic [7:0] ch,
                                                logic [7:0] row, logic [7:0] col,
                                                logic [7:0] color);
      req_payload_type p;
      p.operation  = op;
      p.character  = ch;
      p.target_row = row;
      p.target_col = col;
      p.cell_color = color;
      return p;
   endfunction

   function automatic req_payload_type random_req(int nl_pct, int clr_pct);
      req_payload_type p;
      int              roll;
      p.character  = 8'($urandom_range(0, 255));
      p.target_row = 8'($urandom_range(0, 255));
      p.target_col = 8'($urandom_range(0, 255));
      p.cell_color = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < clr_pct) begin
         p.operation = OP_CLEAR;
      end else if (roll < clr_pct + 2) begin
         p.operation = OP_UNUSED;
      end else if (roll < clr_pct + 20) begin
         p.operation = OP_PLACE;
         // half the placements are forced onto the screen
         if ($urandom_range(0, 1)) begin
            p.target_row = 8'($urandom_range(0, ROWS - 1));
            p.target_col = 8'($urandom_range(0, COLUMNS - 1));
         end
      end else begin
         p.operation = OP_STREAM;
         roll = $urandom_range(0, 99);
         if (roll < nl_pct)
            p.character = CH_NEWLINE;
         else if (roll < nl_pct + 5)
            p.character = CH_RETURN;
         else if (roll < nl_pct + 15)
            p.character = CH_TAB;
         else if (roll < nl_pct + 25)
            p.character = CH_BACKSPACE;
      end
      return p;
   endfunction

   task automatic send_req(req_payload_type p);
      req.valid   <= 1'b1;
      req.payload <= p;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // hold off until every item in flight has come back
   task automatic drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_color(logic [7:0] color);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      colors_used++;
   endtask

   initial begin
      logic [7:0] color;
      req.valid        <= 1'b0;
      req.payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: printable extremes, control codes, placement edges, unused code
      idle_pct = 20;
      send_req(make_req(OP_STREAM, 8'h41, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_req(make_req(OP_STREAM, 8'h00, 8'h00, 8'h00, 8'h00));
      repeat (4) send_req(make_req(OP_STREAM, CH_BACKSPACE, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, CH_TAB, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, CH_TAB, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, CH_RETURN, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, CH_NEWLINE, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, CH_SPACE, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_PLACE, 8'h5A, 8'h00, 8'h00, 8'hFF));
      send_req(make_req(OP_PLACE, 8'hFF, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00));
      send_req(make_req(OP_PLACE, 8'h41, 8'(ROWS), 8'h00, 8'h1E));
      send_req(make_req(OP_PLACE, 8'h41, 8'h00, 8'(COLUMNS), 8'h1E));
      send_req(make_req(OP_PLACE, 8'h41, 8'hFF, 8'hFF, 8'h1E));
      send_req(make_req(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_req(make_req(OP_STREAM, 8'h7E, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_CLEAR, 8'h41, 8'h00, 8'h00, 8'h00));
      send_req(make_req(OP_STREAM, 8'h42, 8'h00, 8'h00, 8'h00));

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)
            color = 8'h00;
         else if (ph == 1)
            color = 8'hFF;
         else
            color = 8'($urandom_range(0, 255));
         write_color(color);
         idle_pct = phase_idle[ph];
         for (int i = 0; i < phase_items[ph]; i++)
            send_req(random_req(phase_nl[ph], phase_clr[ph]));
      end

      drain();
      $display("sent %0d requests under %0d text colors", items_sent, colors_used);
      $display("checked %0d responses, %0d of them scrolled", responses_seen, scrolls_seen);
      if (failures == 0)
         $display("[text_console_cursor_engine] OK");
      else
         $display("[text_console_cursor_engine] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tccur_pkg.sv
rtl/tccur_req_if.sv
rtl/tccur_rsp_if.sv
rtl/tccur_step.sv
rtl/text_console_cursor_engine.sv
rtl/tccur_checker.sv
tb/tccur_cursor_checker.sv
tb/tb.sv
